[rtl/core/vga_register_port_interface_top_defines.svh]
// ----------------------------------------------------------------------------
// vga_register_port_interface_top_defines
// Assertion macros for the VGA register port block.
// ----------------------------------------------------------------------------
`ifndef VGA_REGISTER_PORT_INTERFACE_TOP_DEFINES_SVH
`define VGA_REGISTER_PORT_INTERFACE_TOP_DEFINES_SVH
`ifndef SYNTH
`define VRPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VRPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRPI_ASSERT(lbl, prop, msg)
`define VRPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/vrpi_pkg.sv]
// ----------------------------------------------------------------------------
// vrpi_pkg
// Port codes, defaults and request/response types of the VGA register port.
// ----------------------------------------------------------------------------
package vrpi_pkg;

  localparam int SEQ_COUNT_DEF     = 5;
  localparam int CRTC_COUNT_DEF    = 25;
  localparam int GC_COUNT_DEF      = 9;
  localparam int ATTR_COUNT_DEF    = 21;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_BITS_DEF    = 6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [9:0] PORT_ATTR       = 10'h3C0;
  localparam logic [9:0] PORT_ATTR_RD    = 10'h3C1;
  localparam logic [9:0] PORT_MISC_WR    = 10'h3C2;
  localparam logic [9:0] PORT_SEQ_IDX    = 10'h3C4;
  localparam logic [9:0] PORT_SEQ_DATA   = 10'h3C5;
  localparam logic [9:0] PORT_DAC_RD_IDX = 10'h3C7;
  localparam logic [9:0] PORT_DAC_WR_IDX = 10'h3C8;
  localparam logic [9:0] PORT_DAC_DATA   = 10'h3C9;
  localparam logic [9:0] PORT_MISC_RD    = 10'h3CC;
  localparam logic [9:0] PORT_GC_IDX     = 10'h3CE;
  localparam logic [9:0] PORT_GC_DATA    = 10'h3CF;
  localparam logic [9:0] PORT_CRTC_IDX   = 10'h3D4;
  localparam logic [9:0] PORT_CRTC_DATA  = 10'h3D5;
  localparam logic [9:0] PORT_STATUS     = 10'h3DA;

  localparam int CRTC_PROTECT_REG  = 'h11;
  localparam int CRTC_PROTECT_LAST = 7;
  localparam int CRTC_PROTECT_BIT  = 7;
  localparam int ATTR_DISP_BIT     = 5;

  typedef struct packed {
    logic       exec;
    logic       func;
    logic [9:0] port;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } resp_t;

endpackage

[rtl/core/vga_register_port_interface_top.sv]
// ----------------------------------------------------------------------------
// vga_register_port_interface_top
// A request is taken only while busy is low, executed against the register files and
// palette RAM read data while busy is high, and its result is registered and strobed;
// busy stays high while it executes so the next palette RAM read sees its updates.
// The receiver cannot stall; out_strobe lasts one cycle per request. Synchronous active-low
// reset clears control, regfile and DAC state, not request/result data or palette RAM.
// ----------------------------------------------------------------------------
`include "vga_register_port_interface_top_defines.svh"

module vga_register_port_interface_top #(
  parameter int SEQ_COUNT     = vrpi_pkg::SEQ_COUNT_DEF,
  parameter int CRTC_COUNT    = vrpi_pkg::CRTC_COUNT_DEF,
  parameter int GC_COUNT      = vrpi_pkg::GC_COUNT_DEF,
  parameter int ATTR_COUNT    = vrpi_pkg::ATTR_COUNT_DEF,
  parameter int PALETTE_DEPTH = vrpi_pkg::PALETTE_DEPTH_DEF,
  parameter int COLOR_BITS    = vrpi_pkg::COLOR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_func,
  input  logic [9:0] in_io_port,
  input  logic [7:0] in_io_data,
  output logic       out_strobe,
  output logic [7:0] out_read_data,
  output logic       out_port_hit,
  output logic       out_display_enabled
);

  logic            pending_r;
  logic            func_r;
  logic [9:0]      port_r;
  logic [7:0]      data_r;
  logic            strobe_r;
  logic [7:0]      read_data_r;
  logic            hit_r;
  logic            disp_r;
  logic            accept;
  logic            disp_en;
  vrpi_pkg::req_t  req;
  vrpi_pkg::resp_t reg_resp, dac_resp;

  assign accept = start && !pending_r;
  assign busy   = pending_r;

  assign req.exec = pending_r;
  assign req.func = func_r;
  assign req.port = port_r;
  assign req.data = data_r;

  vrpi_regfile #(
    .SEQ_COUNT  (SEQ_COUNT),
    .CRTC_COUNT (CRTC_COUNT),
    .GC_COUNT   (GC_COUNT),
    .ATTR_COUNT (ATTR_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .resp    (reg_resp),
    .disp_en (disp_en)
  );

  vrpi_dac #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .COLOR_BITS    (COLOR_BITS)
  ) u_dac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .resp  (dac_resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      pending_r <= accept;
      strobe_r  <= pending_r;
    end
    if (accept) begin
      func_r <= in_func;
      port_r <= in_io_port;
      data_r <= in_io_data;
    end
    if (pending_r) begin
      read_data_r <= reg_resp.data | dac_resp.data;
      hit_r       <= reg_resp.hit | dac_resp.hit;
      disp_r      <= disp_en;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_read_data       = read_data_r;
  assign out_port_hit        = hit_r;
  assign out_display_enabled = disp_r;

  `VRPI_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe && !busy, "active after reset")
  `VRPI_ASSERT(a_result_follows, start && !busy |=> busy ##1 out_strobe, "result missing")
  `VRPI_ASSERT(a_strobe_source, out_strobe |-> $past(busy), "strobe without request")
  `VRPI_ASSERT(a_single_exec, busy |=> !busy, "execute cycle repeated")
  `VRPI_ASSERT(a_miss_zero, out_strobe && !out_port_hit |-> out_read_data == 8'd0, "miss data")

endmodule

[rtl/core/vrpi_ram.sv]
// ----------------------------------------------------------------------------
// vrpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrpi_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/vrpi_regfile.sv]
// ----------------------------------------------------------------------------
// vrpi_regfile
// Misc output, sequencer, CRTC, graphics and attribute register groups.
// ----------------------------------------------------------------------------
module vrpi_regfile #(
  parameter int SEQ_COUNT  = vrpi_pkg::SEQ_COUNT_DEF,
  parameter int CRTC_COUNT = vrpi_pkg::CRTC_COUNT_DEF,
  parameter int GC_COUNT   = vrpi_pkg::GC_COUNT_DEF,
  parameter int ATTR_COUNT = vrpi_pkg::ATTR_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vrpi_pkg::req_t req,
  output vrpi_pkg::resp_t resp,
  output logic           disp_en
);

  localparam int SEQ_AW  = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam int CRTC_AW = $clog2(CRTC_COUNT);
  localparam int GC_AW   = (GC_COUNT > 1) ? $clog2(GC_COUNT) : 1;
  localparam int ATTR_AW = $clog2(ATTR_COUNT);

  logic [7:0] misc_r, misc_nxt;
  logic [7:0] seq_idx_r, seq_idx_nxt;
  logic [7:0] crtc_idx_r, crtc_idx_nxt;
  logic [7:0] gc_idx_r, gc_idx_nxt;
  logic [5:0] attr_idx_r, attr_idx_nxt;
  logic       attr_ff_r, attr_ff_nxt;

  logic [7:0] seq_regs_r  [SEQ_COUNT];
  logic [7:0] crtc_regs_r [CRTC_COUNT];
  logic [7:0] gc_regs_r   [GC_COUNT];
  logic [7:0] attr_regs_r [ATTR_COUNT];

  logic       seq_in, crtc_in, gc_in, attr_in, crtc_prot;
  logic [4:0] attr_sel;
  logic       seq_we, crtc_we, gc_we, attr_we;

  assign attr_sel  = attr_idx_r[4:0];
  assign seq_in    = seq_idx_r < 8'(SEQ_COUNT);
  assign crtc_in   = crtc_idx_r < 8'(CRTC_COUNT);
  assign gc_in     = gc_idx_r < 8'(GC_COUNT);
  assign attr_in   = {1'b0, attr_sel} < 6'(ATTR_COUNT);
  assign crtc_prot = crtc_regs_r[CRTC_AW'(vrpi_pkg::CRTC_PROTECT_REG)][vrpi_pkg::CRTC_PROTECT_BIT]
                     && (crtc_idx_r <= 8'(vrpi_pkg::CRTC_PROTECT_LAST));

  always_comb begin
    misc_nxt     = misc_r;
    seq_idx_nxt  = seq_idx_r;
    crtc_idx_nxt = crtc_idx_r;
    gc_idx_nxt   = gc_idx_r;
    attr_idx_nxt = attr_idx_r;
    attr_ff_nxt  = attr_ff_r;
    seq_we       = 1'b0;
    crtc_we      = 1'b0;
    gc_we        = 1'b0;
    attr_we      = 1'b0;
    resp         = '0;
    if (req.exec) begin
      if (req.func == vrpi_pkg::FUNC_READ) begin
        resp.hit = 1'b1;
        case (req.port)
          vrpi_pkg::PORT_MISC_RD:   resp.data = misc_r;
          vrpi_pkg::PORT_SEQ_IDX:   resp.data = seq_idx_r;
          vrpi_pkg::PORT_SEQ_DATA:  resp.data = seq_in ? seq_regs_r[seq_idx_r[SEQ_AW-1:0]] : '0;
          vrpi_pkg::PORT_CRTC_IDX:  resp.data = crtc_idx_r;
          vrpi_pkg::PORT_CRTC_DATA: begin
            resp.data = crtc_in ? crtc_regs_r[crtc_idx_r[CRTC_AW-1:0]] : '0;
          end
          vrpi_pkg::PORT_GC_IDX:    resp.data = gc_idx_r;
          vrpi_pkg::PORT_GC_DATA:   resp.data = gc_in ? gc_regs_r[gc_idx_r[GC_AW-1:0]] : '0;
          vrpi_pkg::PORT_ATTR:      resp.data = {2'b00, attr_idx_r};
          vrpi_pkg::PORT_ATTR_RD:   resp.data = attr_in ? attr_regs_r[attr_sel[ATTR_AW-1:0]] : '0;
          vrpi_pkg::PORT_STATUS:    attr_ff_nxt = 1'b0;
          default:                  resp.hit = 1'b0;
        endcase
      end else begin
        resp.hit = 1'b1;
        case (req.port)
          vrpi_pkg::PORT_MISC_WR:   misc_nxt = req.data;
          vrpi_pkg::PORT_SEQ_IDX:   seq_idx_nxt = req.data;
          vrpi_pkg::PORT_SEQ_DATA:  seq_we = seq_in;
          vrpi_pkg::PORT_CRTC_IDX:  crtc_idx_nxt = req.data;
          vrpi_pkg::PORT_CRTC_DATA: crtc_we = crtc_in && !crtc_prot;
          vrpi_pkg::PORT_GC_IDX:    gc_idx_nxt = req.data;
          vrpi_pkg::PORT_GC_DATA:   gc_we = gc_in;
          vrpi_pkg::PORT_ATTR: begin
            if (!attr_ff_r) begin
              attr_idx_nxt = req.data[5:0];
            end else begin
              attr_we = attr_in;
            end
            attr_ff_nxt = ~attr_ff_r;
          end
          default:                  resp.hit = 1'b0;
        endcase
      end
    end
  end

  assign disp_en = attr_idx_nxt[vrpi_pkg::ATTR_DISP_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      misc_r     <= '0;
      seq_idx_r  <= '0;
      crtc_idx_r <= '0;
      gc_idx_r   <= '0;
      attr_idx_r <= '0;
      attr_ff_r  <= 1'b0;
      for (int i = 0; i < SEQ_COUNT; i++) seq_regs_r[i] <= '0;
      for (int i = 0; i < CRTC_COUNT; i++) crtc_regs_r[i] <= '0;
      for (int i = 0; i < GC_COUNT; i++) gc_regs_r[i] <= '0;
      for (int i = 0; i < ATTR_COUNT; i++) attr_regs_r[i] <= '0;
    end else begin
      misc_r     <= misc_nxt;
      seq_idx_r  <= seq_idx_nxt;
      crtc_idx_r <= crtc_idx_nxt;
      gc_idx_r   <= gc_idx_nxt;
      attr_idx_r <= attr_idx_nxt;
      attr_ff_r  <= attr_ff_nxt;
      if (seq_we) seq_regs_r[seq_idx_r[SEQ_AW-1:0]] <= req.data;
      if (crtc_we) crtc_regs_r[crtc_idx_r[CRTC_AW-1:0]] <= req.data;
      if (gc_we) gc_regs_r[gc_idx_r[GC_AW-1:0]] <= req.data;
      if (attr_we) attr_regs_r[attr_sel[ATTR_AW-1:0]] <= req.data;
    end
  end

endmodule

[rtl/core/vrpi_dac.sv]
// ----------------------------------------------------------------------------
// vrpi_dac
// Palette DAC: read/write indices, component sequencing and palette RAM.
// ----------------------------------------------------------------------------
module vrpi_dac #(
  parameter int PALETTE_DEPTH = vrpi_pkg::PALETTE_DEPTH_DEF,
  parameter int COLOR_BITS    = vrpi_pkg::COLOR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  vrpi_pkg::req_t  req,
  output vrpi_pkg::resp_t resp
);

  localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
  localparam int ENTRY_W = 3 * COLOR_BITS;

  typedef enum logic [1:0] {COMP_RED, COMP_GREEN, COMP_BLUE} comp_t;

  comp_t                    comp_r, comp_nxt;
  logic [7:0]               wr_idx_r, wr_idx_nxt;
  logic [7:0]               rd_idx_r, rd_idx_nxt;
  logic [2*COLOR_BITS-1:0]  latch_r, latch_nxt;
  logic                     wr_in, rd_in;
  logic [ENTRY_W-1:0]       ram_rdata, entry;
  logic [COLOR_BITS-1:0]    c_in, c_out;
  logic                     ram_we;

  assign wr_in = {1'b0, wr_idx_r} < 9'(PALETTE_DEPTH);
  assign rd_in = {1'b0, rd_idx_r} < 9'(PALETTE_DEPTH);
  assign entry = rd_in ? ram_rdata : '0;
  assign c_in  = req.data[COLOR_BITS-1:0];

  // Read address is the read index held since the request was taken.
  vrpi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r[PAL_AW-1:0]),
    .wdata ({c_in, latch_r}),
    .raddr (rd_idx_r[PAL_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    comp_nxt   = comp_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    latch_nxt  = latch_r;
    ram_we     = 1'b0;
    c_out      = '0;
    resp       = '0;
    if (req.exec) begin
      if (req.func == vrpi_pkg::FUNC_READ) begin
        resp.hit = 1'b1;
        case (req.port)
          vrpi_pkg::PORT_DAC_RD_IDX: resp.data = '0;
          vrpi_pkg::PORT_DAC_WR_IDX: resp.data = wr_idx_r;
          vrpi_pkg::PORT_DAC_DATA: begin
            case (comp_r)
              COMP_RED: begin
                c_out    = entry[COLOR_BITS-1:0];
                comp_nxt = COMP_GREEN;
              end
              COMP_GREEN: begin
                c_out    = entry[2*COLOR_BITS-1:COLOR_BITS];
                comp_nxt = COMP_BLUE;
              end
              default: begin
                c_out      = entry[ENTRY_W-1:2*COLOR_BITS];
                rd_idx_nxt = rd_idx_r + 8'd1;
                comp_nxt   = COMP_RED;
              end
            endcase
            resp.data = 8'(c_out);
          end
          default: resp.hit = 1'b0;
        endcase
      end else begin
        resp.hit = 1'b1;
        case (req.port)
          vrpi_pkg::PORT_DAC_RD_IDX: begin
            rd_idx_nxt = req.data;
            comp_nxt   = COMP_RED;
          end
          vrpi_pkg::PORT_DAC_WR_IDX: begin
            wr_idx_nxt = req.data;
            comp_nxt   = COMP_RED;
          end
          vrpi_pkg::PORT_DAC_DATA: begin
            case (comp_r)
              COMP_RED: begin
                latch_nxt = {{COLOR_BITS{1'b0}}, c_in};
                comp_nxt  = COMP_GREEN;
              end
              COMP_GREEN: begin
                latch_nxt = {c_in, latch_r[COLOR_BITS-1:0]};
                comp_nxt  = COMP_BLUE;
              end
              default: begin
                ram_we     = wr_in;
                wr_idx_nxt = wr_idx_r + 8'd1;
                comp_nxt   = COMP_RED;
              end
            endcase
          end
          default: resp.hit = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r   <= COMP_RED;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      latch_r  <= '0;
    end else begin
      comp_r   <= comp_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      latch_r  <= latch_nxt;
    end
  end

endmodule

[sim/vga_register_port_interface_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vga_register_port_interface_top_tb
// Drives single I/O bus accesses into the VGA register port through the
// start/busy handshake and predicts every result from a shadow copy of the
// register groups and palette DAC. A short directed pass covers port decode,
// CRTC write protect, out-of-range indexes, the attribute flip-flop and DAC
// wrap. Random index/data, attribute and DAC sequences with noise follow,
// with bursty idling and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module vga_register_port_interface_top_tb;
  import vrpi_pkg::*;

  localparam int SEQ_N          = SEQ_COUNT_DEF;
  localparam int CRTC_N         = CRTC_COUNT_DEF;
  localparam int GC_N           = GC_COUNT_DEF;
  localparam int ATTR_N         = ATTR_COUNT_DEF;
  localparam int PAL_N          = PALETTE_DEPTH_DEF;
  localparam int CB             = COLOR_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CHUNK_ITEMS    = 100;
  localparam int RANDOM_CHUNKS  = 13;
  localparam int BURST_ITEMS    = 120;

  localparam logic [9:0] PORT_NONE_LO = 10'h000;
  localparam logic [9:0] PORT_NONE_HI = 10'h3FF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_hit;
    logic       display_enabled;
  } io_result_t;

  typedef enum logic [1:0] {DAC_RED, DAC_GREEN, DAC_BLUE} dac_phase_t;

  typedef enum int {
    TRAFFIC_MISC, TRAFFIC_SEQ, TRAFFIC_CRTC, TRAFFIC_GC,
    TRAFFIC_ATTR, TRAFFIC_DAC_WR, TRAFFIC_DAC_RD, TRAFFIC_NOISE
  } traffic_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_func = FUNC_WRITE;
  logic [9:0] in_io_port = '0;
  logic [7:0] in_io_data = '0;
  logic       out_strobe;
  logic [7:0] out_read_data;
  logic       out_port_hit;
  logic       out_display_enabled;

  // shadow register file
  logic [7:0]      misc_reg;
  logic [7:0]      seq_idx, crtc_idx, gc_idx;
  logic [7:0]      seq_file [SEQ_N];
  logic [7:0]      crtc_file [CRTC_N];
  logic [7:0]      gc_file [GC_N];
  logic [5:0]      attr_idx;
  logic [7:0]      attr_file [ATTR_N];
  logic            attr_data_phase;
  logic [7:0]      dac_wr_idx, dac_rd_idx;
  dac_phase_t      dac_phase;
  logic [2*CB-1:0] dac_latch;
  logic [3*CB-1:0] palette [PAL_N];
  bit              palette_valid [PAL_N];
  logic [7:0]      palette_last;

  io_result_t pending_results[$];
  int         errors = 0;
  int         requests_sent = 0;
  int         idle_pct = 0;
  int         idle_cycles = 0;

  vga_register_port_interface_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_io_port          (in_io_port),
    .in_io_data          (in_io_data),
    .out_strobe          (out_strobe),
    .out_read_data       (out_read_data),
    .out_port_hit        (out_port_hit),
    .out_display_enabled (out_display_enabled)
  );

  always #5 clk = ~clk;

  function automatic io_result_t vga_io_access(logic rd, logic [9:0] port, logic [7:0] v);
    io_result_t      r;
    logic [3*CB-1:0] entry;
    r = '0;
    r.port_hit = 1'b1;
    if (rd == FUNC_READ) begin
      case (port)
        PORT_MISC_RD:    r.read_data = misc_reg;
        PORT_SEQ_IDX:    r.read_data = seq_idx;
        PORT_SEQ_DATA:   if (seq_idx < SEQ_N) r.read_data = seq_file[seq_idx];
        PORT_CRTC_IDX:   r.read_data = crtc_idx;
        PORT_CRTC_DATA:  if (crtc_idx < CRTC_N) r.read_data = crtc_file[crtc_idx];
        PORT_GC_IDX:     r.read_data = gc_idx;
        PORT_GC_DATA:    if (gc_idx < GC_N) r.read_data = gc_file[gc_idx];
        PORT_ATTR:       r.read_data = {2'b00, attr_idx};
        PORT_ATTR_RD:    if (attr_idx[4:0] < ATTR_N) r.read_data = attr_file[attr_idx[4:0]];
        PORT_STATUS:     attr_data_phase = 1'b0;
        PORT_DAC_RD_IDX: r.read_data = '0;
        PORT_DAC_WR_IDX: r.read_data = dac_wr_idx;
        PORT_DAC_DATA: begin
          entry = (dac_rd_idx < PAL_N) ? palette[dac_rd_idx] : '0;
          case (dac_phase)
            DAC_RED: begin
              r.read_data = 8'(entry[CB-1:0]);
              dac_phase = DAC_GREEN;
            end
            DAC_GREEN: begin
              r.read_data = 8'(entry[2*CB-1:CB]);
              dac_phase = DAC_BLUE;
            end
            default: begin
              r.read_data = 8'(entry[3*CB-1:2*CB]);
              dac_rd_idx = dac_rd_idx + 8'd1;
              dac_phase = DAC_RED;
            end
          endcase
        end
        default: r.port_hit = 1'b0;
      endcase
    end else begin
      case (port)
        PORT_MISC_WR:  misc_reg = v;
        PORT_SEQ_IDX:  seq_idx = v;
        PORT_SEQ_DATA: if (seq_idx < SEQ_N) seq_file[seq_idx] = v;
        PORT_CRTC_IDX: crtc_idx = v;
        PORT_CRTC_DATA: begin
          if (!(crtc_idx <= CRTC_PROTECT_LAST && crtc_file[CRTC_PROTECT_REG][CRTC_PROTECT_BIT])
              && crtc_idx < CRTC_N)
            crtc_file[crtc_idx] = v;
        end
        PORT_GC_IDX:   gc_idx = v;
        PORT_GC_DATA:  if (gc_idx < GC_N) gc_file[gc_idx] = v;
        PORT_ATTR: begin
          if (!attr_data_phase) attr_idx = v[5:0];
          else if (attr_idx[4:0] < ATTR_N) attr_file[attr_idx[4:0]] = v;
          attr_data_phase = ~attr_data_phase;
        end
        PORT_DAC_RD_IDX: begin
          dac_rd_idx = v;
          dac_phase = DAC_RED;
        end
        PORT_DAC_WR_IDX: begin
          dac_wr_idx = v;
          dac_phase = DAC_RED;
        end
        PORT_DAC_DATA: begin
          case (dac_phase)
            DAC_RED: begin
              dac_latch = {{CB{1'b0}}, v[CB-1:0]};
              dac_phase = DAC_GREEN;
            end
            DAC_GREEN: begin
              dac_latch = {v[CB-1:0], dac_latch[CB-1:0]};
              dac_phase = DAC_BLUE;
            end
            default: begin
              if (dac_wr_idx < PAL_N) begin
                palette[dac_wr_idx] = {v[CB-1:0], dac_latch};
                palette_valid[dac_wr_idx] = 1'b1;
                palette_last = dac_wr_idx;
              end
              dac_wr_idx = dac_wr_idx + 8'd1;
              dac_phase = DAC_RED;
            end
          endcase
        end
        default: r.port_hit = 1'b0;
      endcase
    end
    r.display_enabled = attr_idx[ATTR_DISP_BIT];
    return r;
  endfunction

  // one request through the handshake; start stays high unless an idle burst follows
  task automatic send_request(input logic rd, input logic [9:0] port, input logic [7:0] v);
    logic [9:0] p;
    int         gap;
    p = port;
    // never read a palette entry that was not written
    if (rd == FUNC_READ && p == PORT_DAC_DATA && !palette_valid[dac_rd_idx])
      p = PORT_DAC_RD_IDX;
    start <= 1'b1;
    in_func <= rd;
    in_io_port <= p;
    in_io_data <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(vga_io_access(rd, p, v));
    requests_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(5, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic index_data_traffic(input logic [9:0] idx_port, input logic [9:0] data_port,
                                    input int depth);
    logic [7:0] idx;
    int         n;
    idx = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(depth - 1));
    send_request(FUNC_WRITE, idx_port, idx);
    n = $urandom_range(3, 1);
    repeat (n) begin
      case ($urandom_range(4))
        0:       send_request(FUNC_READ, idx_port, 8'($urandom));
        1, 2:    send_request(FUNC_WRITE, data_port, 8'($urandom));
        default: send_request(FUNC_READ, data_port, 8'($urandom));
      endcase
    end
  endtask

  task automatic run_traffic(input int count);
    int         goal;
    int         n;
    traffic_t   kind;
    logic [7:0] idx;
    logic [9:0] port;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      kind = traffic_t'($urandom_range(TRAFFIC_NOISE));
      case (kind)
        TRAFFIC_MISC: begin
          send_request(FUNC_WRITE, PORT_MISC_WR, 8'($urandom));
          send_request(FUNC_READ, PORT_MISC_RD, 8'($urandom));
        end
        TRAFFIC_SEQ:  index_data_traffic(PORT_SEQ_IDX, PORT_SEQ_DATA, SEQ_N);
        TRAFFIC_CRTC: index_data_traffic(PORT_CRTC_IDX, PORT_CRTC_DATA, CRTC_N);
        TRAFFIC_GC:   index_data_traffic(PORT_GC_IDX, PORT_GC_DATA, GC_N);
        TRAFFIC_ATTR: begin
          if ($urandom_range(3) != 0) send_request(FUNC_READ, PORT_STATUS, 8'($urandom));
          send_request(FUNC_WRITE, PORT_ATTR, 8'($urandom));
          if ($urandom_range(3) != 0) send_request(FUNC_WRITE, PORT_ATTR, 8'($urandom));
          send_request(FUNC_READ, PORT_ATTR_RD, 8'($urandom));
          send_request(FUNC_READ, PORT_ATTR, 8'($urandom));
        end
        TRAFFIC_DAC_WR: begin
          send_request(FUNC_WRITE, PORT_DAC_WR_IDX, 8'($urandom));
          n = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : 3 * $urandom_range(4, 1);
          repeat (n) send_request(FUNC_WRITE, PORT_DAC_DATA, 8'($urandom));
          if ($urandom_range(3) == 0) send_request(FUNC_READ, PORT_DAC_WR_IDX, 8'($urandom));
        end
        TRAFFIC_DAC_RD: begin
          idx = 8'($urandom);
          if (!palette_valid[idx]) idx = palette_last;
          send_request(FUNC_WRITE, PORT_DAC_RD_IDX, idx);
          n = $urandom_range(6, 1);
          repeat (n) send_request(FUNC_READ, PORT_DAC_DATA, 8'($urandom));
          if ($urandom_range(3) == 0) send_request(FUNC_READ, PORT_DAC_RD_IDX, 8'($urandom));
        end
        default: begin
          port = $urandom_range(1) ? 10'($urandom) : PORT_ATTR + 10'($urandom_range(31));
          send_request(logic'($urandom_range(1)), port, 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_port_decode();
    send_request(FUNC_WRITE, PORT_MISC_WR, 8'hFF);
    send_request(FUNC_READ, PORT_MISC_RD, 8'h00);
    send_request(FUNC_READ, PORT_MISC_WR, 8'h00);
    send_request(FUNC_WRITE, PORT_MISC_RD, 8'h00);
    send_request(FUNC_WRITE, PORT_STATUS, 8'hA5);
    send_request(FUNC_WRITE, PORT_ATTR_RD, 8'h5A);
    send_request(FUNC_READ, PORT_NONE_LO, 8'h00);
    send_request(FUNC_WRITE, PORT_NONE_HI, 8'hFF);
  endtask

  task automatic test_index_limits();
    send_request(FUNC_WRITE, PORT_CRTC_IDX, 8'(CRTC_PROTECT_REG));
    send_request(FUNC_WRITE, PORT_CRTC_DATA, 8'h80);
    send_request(FUNC_WRITE, PORT_CRTC_IDX, 8'h00);
    send_request(FUNC_WRITE, PORT_CRTC_DATA, 8'hFF);
    send_request(FUNC_READ, PORT_CRTC_DATA, 8'h00);
    send_request(FUNC_WRITE, PORT_SEQ_IDX, 8'hFF);
    send_request(FUNC_WRITE, PORT_SEQ_DATA, 8'h77);
    send_request(FUNC_READ, PORT_SEQ_DATA, 8'h00);
  endtask

  task automatic test_attr_flipflop();
    send_request(FUNC_READ, PORT_STATUS, 8'h00);
    send_request(FUNC_WRITE, PORT_ATTR, 8'hFF);
    send_request(FUNC_WRITE, PORT_ATTR, 8'h12);
    send_request(FUNC_WRITE, PORT_ATTR, 8'h03);
    send_request(FUNC_WRITE, PORT_ATTR, 8'hC3);
    send_request(FUNC_READ, PORT_ATTR_RD, 8'h00);
  endtask

  task automatic test_palette_wrap();
    send_request(FUNC_WRITE, PORT_DAC_WR_IDX, 8'hFF);
    send_request(FUNC_WRITE, PORT_DAC_DATA, 8'hFF);
    send_request(FUNC_WRITE, PORT_DAC_DATA, 8'hC0);
    send_request(FUNC_WRITE, PORT_DAC_DATA, 8'h3F);
    send_request(FUNC_WRITE, PORT_DAC_RD_IDX, 8'hFF);
    repeat (3) send_request(FUNC_READ, PORT_DAC_DATA, 8'h00);
    send_request(FUNC_READ, PORT_DAC_WR_IDX, 8'h00);
  endtask

  task automatic test_random_traffic();
    repeat (RANDOM_CHUNKS) begin
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      run_traffic(CHUNK_ITEMS);
    end
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_traffic(BURST_ITEMS);
  endtask

  always @(posedge clk) begin : result_check
    io_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, out_read_data);
          errors++;
        end
        if (out_port_hit !== want.port_hit) begin
          $error("port_hit: expected %0b, actual %0b", want.port_hit, out_port_hit);
          errors++;
        end
        if (out_display_enabled !== want.display_enabled) begin
          $error("display_enabled: expected %0b, actual %0b",
                 want.display_enabled, out_display_enabled);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    misc_reg = '0;
    seq_idx = '0;
    crtc_idx = '0;
    gc_idx = '0;
    attr_idx = '0;
    attr_data_phase = 1'b0;
    dac_wr_idx = '0;
    dac_rd_idx = '0;
    dac_phase = DAC_RED;
    dac_latch = '0;
    palette_last = '0;
    foreach (seq_file[i]) seq_file[i] = '0;
    foreach (crtc_file[i]) crtc_file[i] = '0;
    foreach (gc_file[i]) gc_file[i] = '0;
    foreach (attr_file[i]) attr_file[i] = '0;
    foreach (palette[i]) begin
      palette[i] = '0;
      palette_valid[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_port_decode();
    test_index_limits();
    test_attr_flipflop();
    test_palette_wrap();
    test_random_traffic();
    test_back_to_back();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
